FILE: hdl/kbp_pkg.sv
// Shared types and constants of the keypoint back-projection block.
`default_nettype none
package kbp_pkg;
	localparam int ROW_W    = 63;
	localparam int COEF_W   = 21;
	localparam int SCALE_W  = 24;
	localparam int U_W      = 10;
	localparam int V_W      = 9;
	localparam int CODE_W   = 8;
	localparam int OUT_W    = 40;
	localparam int Z_W      = 39;
	localparam int DEPTH_W  = 32;
	localparam int MAG_W    = 32;
	localparam int NUM_W    = 63;
	localparam int PROD_W   = 32;
	localparam int SUM_W    = 34;
	localparam int BASE_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [BASE_W-1:0] DEPTH_BASE  = 16'd65280;
	localparam logic [BASE_W-1:0] DEPTH_SLOPE = 16'd205;

	localparam logic [ROW_W-1:0]   INV_ROW0_RST = 63'd262144;
	localparam logic [ROW_W-1:0]   INV_ROW1_RST = 63'd549755813888;
	localparam logic [ROW_W-1:0]   INV_ROW2_RST = 63'd1152921504606846976;
	localparam logic [SCALE_W-1:0] SCALE_RST    = 24'd65536;

	localparam logic [OUT_W-1:0] OUT_MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MAX_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_ROW0    = 2'd0,
		CFG_INV_ROW1    = 2'd1,
		CFG_INV_ROW2    = 2'd2,
		CFG_DEPTH_SCALE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [NUM_W-1:0]   numx;
		logic [NUM_W-1:0]   numy;
		logic [MAG_W-1:0]   den;
		logic               negx;
		logic               negy;
		logic               zero;
		logic [DEPTH_W-1:0] depth;
		logic               last;
	} div_in_t;

	typedef struct packed {
		logic [NUM_W-1:0]   qx;
		logic [NUM_W-1:0]   qy;
		logic               negx;
		logic               negy;
		logic               zero;
		logic [DEPTH_W-1:0] depth;
		logic               last;
	} div_out_t;
endpackage
`default_nettype wire

FILE: hdl/kbp_front.sv
// Front pipeline: matrix products, depth conversion, magnitudes and numerators.
`default_nettype none
module kbp_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_vld,
	input  wire logic [kbp_pkg::U_W-1:0]         pixel_u,
	input  wire logic [kbp_pkg::V_W-1:0]         pixel_v,
	input  wire logic [kbp_pkg::CODE_W-1:0]      depth_code,
	input  wire logic                            last_point,
	input  wire logic [kbp_pkg::ROW_W-1:0]       row0,
	input  wire logic [kbp_pkg::ROW_W-1:0]       row1,
	input  wire logic [kbp_pkg::ROW_W-1:0]       row2,
	input  wire logic [kbp_pkg::SCALE_W-1:0]     scale,
	output logic                                 out_vld,
	output kbp_pkg::div_in_t                     dout
);
	localparam int CW = kbp_pkg::COEF_W;
	localparam int PW = kbp_pkg::PROD_W;
	localparam int SW = kbp_pkg::SUM_W;

	// stage 1: per-coefficient products
	logic                  vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0]  pu_s1 [3];
	logic signed [PW-1:0]  pv_s1 [3];
	logic signed [CW-1:0]  pc_s1 [3];
	logic [kbp_pkg::BASE_W-1:0] base_s1;
	logic                  last_s1;

	// stage 2: dot products and depth
	logic signed [SW-1:0]  d_s2 [3];
	logic [kbp_pkg::DEPTH_W-1:0] depth_s2;
	logic                  last_s2;

	logic [kbp_pkg::ROW_W-1:0] rows [3];
	logic signed [SW-1:0]      dsum [3];
	logic [kbp_pkg::MAG_W-1:0] mag [3];
	logic [kbp_pkg::BASE_W+kbp_pkg::SCALE_W-1:0] dprod;

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			dsum[r] = SW'(pu_s1[r]) + SW'(pv_s1[r]) + SW'(pc_s1[r]);
			mag[r]  = d_s2[r][SW-1] ? kbp_pkg::MAG_W'(-d_s2[r]) : kbp_pkg::MAG_W'(d_s2[r]);
		end
		dprod = (kbp_pkg::BASE_W+kbp_pkg::SCALE_W)'(base_s1) * 
			(kbp_pkg::BASE_W+kbp_pkg::SCALE_W)'(scale);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pu_s1[r] <= $signed(rows[r][CW-1:0]) * $signed({1'b0, pixel_u});
				pv_s1[r] <= $signed(rows[r][2*CW-1:CW]) * $signed({1'b0, pixel_v});
				pc_s1[r] <= $signed(rows[r][3*CW-1:2*CW]);
				d_s2[r]  <= dsum[r];
			end
			base_s1  <= kbp_pkg::DEPTH_BASE - kbp_pkg::BASE_W'(depth_code) * kbp_pkg::DEPTH_SLOPE;
			last_s1  <= last_point;
			depth_s2 <= dprod[kbp_pkg::DEPTH_W+7:8];
			last_s2  <= last_s1;
			// stage 3: numerators |d|*depth, divisor |dz|
			dout.numx  <= kbp_pkg::NUM_W'(64'(mag[0]) * 64'(depth_s2));
			dout.numy  <= kbp_pkg::NUM_W'(64'(mag[1]) * 64'(depth_s2));
			dout.den   <= mag[2];
			dout.negx  <= d_s2[0][SW-1] ^ d_s2[2][SW-1];
			dout.negy  <= d_s2[1][SW-1] ^ d_s2[2][SW-1];
			dout.zero  <= (d_s2[2] == '0);
			dout.depth <= depth_s2;
			dout.last  <= last_s2;
		end
	end

	assign out_vld = vld_s3;
endmodule
`default_nettype wire

FILE: hdl/kbp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel.
`default_nettype none
module kbp_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  kbp_pkg::div_in_t       din,
	output logic                   out_vld,
	output kbp_pkg::div_out_t      dout
);
	localparam int NW = kbp_pkg::NUM_W;
	localparam int MW = kbp_pkg::MAG_W;

	typedef struct packed {
		logic [MW-1:0]              remx;
		logic [NW-1:0]              nqx;
		logic [MW-1:0]              remy;
		logic [NW-1:0]              nqy;
		logic [MW-1:0]              den;
		logic                       negx;
		logic                       negy;
		logic                       zero;
		logic [kbp_pkg::DEPTH_W-1:0] depth;
		logic                       last;
	} dstage_t;

	typedef struct packed {
		logic [MW-1:0] rem;
		logic [NW-1:0] nq;
	} step_t;

	function automatic step_t div_step(logic [MW-1:0] rem, logic [NW-1:0] nq,
		logic [MW-1:0] den);
		logic [MW:0] t;
		logic        ge;
		step_t       s;
		t      = {rem, nq[NW-1]};
		ge     = (t >= {1'b0, den});
		s.rem  = ge ? MW'(t - {1'b0, den}) : MW'(t);
		s.nq   = {nq[NW-2:0], ge};
		return s;
	endfunction

	dstage_t cur_sd [NW+1];
	logic    vld_sd [NW+1];

	always_comb begin
		cur_sd[0].remx  = '0;
		cur_sd[0].nqx   = din.numx;
		cur_sd[0].remy  = '0;
		cur_sd[0].nqy   = din.numy;
		cur_sd[0].den   = din.den;
		cur_sd[0].negx  = din.negx;
		cur_sd[0].negy  = din.negy;
		cur_sd[0].zero  = din.zero;
		cur_sd[0].depth = din.depth;
		cur_sd[0].last  = din.last;
		vld_sd[0]       = in_vld;
	end

	for (genvar i = 0; i < NW; i++) begin : g_step
		step_t   sx, sy;
		dstage_t nxt;
		assign sx = div_step(cur_sd[i].remx, cur_sd[i].nqx, cur_sd[i].den);
		assign sy = div_step(cur_sd[i].remy, cur_sd[i].nqy, cur_sd[i].den);

		always_comb begin
			nxt      = cur_sd[i];
			nxt.remx = sx.rem;
			nxt.nqx  = sx.nq;
			nxt.remy = sy.rem;
			nxt.nqy  = sy.nq;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i+1] <= 1'b0;
			end else if (en) begin
				vld_sd[i+1] <= vld_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cur_sd[i+1] <= nxt;
			end
		end
	end

	assign out_vld    = vld_sd[NW];
	assign dout.qx    = cur_sd[NW].nqx;
	assign dout.qy    = cur_sd[NW].nqy;
	assign dout.negx  = cur_sd[NW].negx;
	assign dout.negy  = cur_sd[NW].negy;
	assign dout.zero  = cur_sd[NW].zero;
	assign dout.depth = cur_sd[NW].depth;
	assign dout.last  = cur_sd[NW].last;
endmodule
`default_nettype wire

FILE: hdl/keypoint_back_projection.sv
// Top level of the keypoint back-projection block.
`default_nettype none
// Back-projects one keypoint (u, v, depth code) a transaction into a camera-space
// point. Direction (dx,dy,dz) = Kinv*(u,v,1) with Q3.18 coefficients; depth =
// ((65280 - 205*code) * depth_scale) >> 8 in Q.16; x = trunc(dx*depth/dz),
// y likewise, saturated to signed 40 bits. dz == 0 gives x = y = 0 and div_zero.
// Throughput is one transaction per clock while no valid output is stalled.
// The pipeline has three front stages (products, dot sums with the depth
// multiply, magnitudes with the numerator multiplies), 63 restoring-divider
// stages, each producing one quotient bit of the 63-bit numerator, and one
// saturation/output register. The whole pipeline advances together; it holds
// when a valid output is stalled, which raises in_stall combinationally.
// Configuration writes are always taken (cfg_ready is tied high); write them
// only while the pipeline is empty.
module keypoint_back_projection (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kbp_pkg::ROW_W-1:0]       cfg_data,
	// keypoint channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [kbp_pkg::U_W-1:0]         pixel_u,
	input  wire logic [kbp_pkg::V_W-1:0]         pixel_v,
	input  wire logic [kbp_pkg::CODE_W-1:0]      depth_code,
	input  wire logic                            last_point,
	// point channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [kbp_pkg::OUT_W-1:0]            x_out,
	output logic [kbp_pkg::OUT_W-1:0]            y_out,
	output logic [kbp_pkg::Z_W-1:0]              z_out,
	output logic                                 div_zero,
	output logic                                 end_of_set
);
	localparam int OW = kbp_pkg::OUT_W;

	logic [kbp_pkg::ROW_W-1:0]   inv_row0_q, inv_row1_q, inv_row2_q;
	logic [kbp_pkg::SCALE_W-1:0] depth_scale_q;

	// global advance: everything moves unless a held result is stalled
	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_row0_q    <= kbp_pkg::INV_ROW0_RST;
			inv_row1_q    <= kbp_pkg::INV_ROW1_RST;
			inv_row2_q    <= kbp_pkg::INV_ROW2_RST;
			depth_scale_q <= kbp_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (kbp_pkg::cfg_idx_t'(cfg_index))
				kbp_pkg::CFG_INV_ROW0:    inv_row0_q <= cfg_data;
				kbp_pkg::CFG_INV_ROW1:    inv_row1_q <= cfg_data;
				kbp_pkg::CFG_INV_ROW2:    inv_row2_q <= cfg_data;
				kbp_pkg::CFG_DEPTH_SCALE: depth_scale_q <= cfg_data[kbp_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	logic              front_vld, div_vld;
	kbp_pkg::div_in_t  front_d;
	kbp_pkg::div_out_t div_d;

	kbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (in_valid),
		.pixel_u    (pixel_u),
		.pixel_v    (pixel_v),
		.depth_code (depth_code),
		.last_point (last_point),
		.row0       (inv_row0_q),
		.row1       (inv_row1_q),
		.row2       (inv_row2_q),
		.scale      (depth_scale_q),
		.out_vld    (front_vld),
		.dout       (front_d)
	);

	kbp_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (front_vld),
		.din     (front_d),
		.out_vld (div_vld),
		.dout    (div_d)
	);

	// saturate magnitude and apply sign
	function automatic logic [OW-1:0] sat_signed(logic [kbp_pkg::NUM_W-1:0] q, logic neg);
		logic big;
		big = (q[kbp_pkg::NUM_W-1:OW-1] != '0);
		if (neg)
			return big ? kbp_pkg::OUT_MAX_NEG : OW'(-q[OW-1:0]);
		else
			return big ? kbp_pkg::OUT_MAX_POS : q[OW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out      <= div_d.zero ? '0 : sat_signed(div_d.qx, div_d.negx);
			y_out      <= div_d.zero ? '0 : sat_signed(div_d.qy, div_d.negy);
			// depth stays below 2^32, far under the z limit
			z_out      <= kbp_pkg::Z_W'(div_d.depth);
			div_zero   <= div_d.zero;
			end_of_set <= div_d.last;
		end
	end

	// a zero divisor always comes out with both coordinates cleared
	a_div_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> x_out == '0 && y_out == '0)
		else $error("div_zero result with nonzero x or y");

	// converted depth never reaches the upper bits of z
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> z_out[kbp_pkg::Z_W-1:kbp_pkg::DEPTH_W] == '0)
		else $error("depth out of range");

	// input is held exactly when a result waits stalled
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not track output hold");
endmodule
`default_nettype wire
